[rtl/mahd_pkg.sv]
// Package for the MPEG audio header decoder.
// Holds field codes, status codes, the bitrate and sample-rate tables, and the
// stage records passed between the decode and frame-size modules.
package mahd_pkg;

  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSVD   = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  localparam logic [1:0] LAYER_RSVD = 2'd0;
  localparam logic [1:0] LAYER_3    = 2'd1;
  localparam logic [1:0] LAYER_2    = 2'd2;
  localparam logic [1:0] LAYER_1    = 2'd3;

  localparam logic [3:0] BRI_FREE = 4'd0;
  localparam logic [3:0] BRI_BAD  = 4'hF;
  localparam logic [1:0] SRI_RSVD = 2'd3;
  localparam logic [1:0] MODE_MONO = 2'd3;

  // ceil(2^27 / 147); exact floor division for products below 2^20
  localparam int unsigned   RECIP_SHIFT = 27;
  localparam logic [19:0]   RECIP_147   = 20'd913046;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_VER   = 3'd1,
    ST_BAD_LAYER = 3'd2,
    ST_BAD_RATE  = 3'd3,
    ST_BAD_SRATE = 3'd4
  } status_e;

  // divisor left after factoring the sample rate into base * 2^shift
  typedef enum logic [1:0] {
    DIV_ONE = 2'd0,
    DIV_TWO = 2'd1,
    DIV_147 = 2'd2
  } div_e;

  localparam logic [8:0] BR_TAB [0:4][0:13] = '{
    '{9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160,
      9'd192, 9'd224, 9'd256, 9'd320},
    '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192,
      9'd224, 9'd256, 9'd320, 9'd384},
    '{9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd288,
      9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
    '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd144, 9'd160},
    '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160,
      9'd176, 9'd192, 9'd224, 9'd256}
  };

  function automatic logic [15:0] srate_lookup(logic [1:0] ver, logic [1:0] sri);
    logic [15:0] hz;
    hz = 16'd0;
    unique case ({ver, sri})
      {VER_MPEG25, 2'd0}: hz = 16'd11025;
      {VER_MPEG25, 2'd1}: hz = 16'd12000;
      {VER_MPEG25, 2'd2}: hz = 16'd8000;
      {VER_MPEG2, 2'd0}:  hz = 16'd22050;
      {VER_MPEG2, 2'd1}:  hz = 16'd24000;
      {VER_MPEG2, 2'd2}:  hz = 16'd16000;
      {VER_MPEG1, 2'd0}:  hz = 16'd44100;
      {VER_MPEG1, 2'd1}:  hz = 16'd48000;
      {VER_MPEG1, 2'd2}:  hz = 16'd32000;
      default:            hz = 16'd0;
    endcase
    return hz;
  endfunction

  typedef struct packed {
    status_e     status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [10:0] samples_per_frame;
    logic [1:0]  crc_bytes;
    logic [5:0]  side_info_bytes;
    logic [10:0] mult;
    div_e        div_sel;
    logic [1:0]  shift;
    logic        pad;
    logic        slot4;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [10:0] samples_per_frame;
    logic [11:0] frame_bytes;
    logic [1:0]  crc_bytes;
    logic [5:0]  side_info_bytes;
  } res_t;

endpackage

[rtl/mahd_decode.sv]
// First pipeline stage: field extraction, status check and table lookups.
// Depends on mahd_pkg.
module mahd_decode import mahd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  output logic        dec_valid_o,
  input  logic        dec_ready_i,
  output hdr_t        dec_o
);

  logic       v_q;
  logic       ready;
  hdr_t       hdr_d, hdr_q;

  logic [1:0] ver, lay, sri, mode;
  logic [3:0] bri, bidx;
  logic [2:0] row;
  logic [1:0] cidx;
  status_e    st;

  assign ver  = header_word_i[20:19];
  assign lay  = header_word_i[18:17];
  assign bri  = header_word_i[15:12];
  assign sri  = header_word_i[11:10];
  assign mode = header_word_i[7:6];
  assign bidx = bri - 4'd1;

  always_comb begin
    if (ver == VER_RSVD) begin
      st = ST_BAD_VER;
    end else if (lay == LAYER_RSVD) begin
      st = ST_BAD_LAYER;
    end else if (bri == BRI_FREE || bri == BRI_BAD) begin
      st = ST_BAD_RATE;
    end else if (sri == SRI_RSVD) begin
      st = ST_BAD_SRATE;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    if (ver == VER_MPEG1) begin
      row = 3'(lay - 2'd1);
    end else if (lay == LAYER_1) begin
      row = 3'd4;
    end else begin
      row = 3'd3;
    end
    // coefficient class: 0 -> 12000, 1 -> 144000, 2 -> 72000
    if (lay == LAYER_1) begin
      cidx = 2'd0;
    end else if (lay == LAYER_2 || ver == VER_MPEG1) begin
      cidx = 2'd1;
    end else begin
      cidx = 2'd2;
    end
  end

  always_comb begin
    hdr_d = '0;
    hdr_d.status       = st;
    hdr_d.version_code = ver;
    hdr_d.layer_code   = lay;
    hdr_d.crc_bytes    = header_word_i[16] ? 2'd0 : 2'd2;
    hdr_d.div_sel      = DIV_ONE;
    if (st == ST_OK) begin
      hdr_d.bitrate_kbps   = BR_TAB[row][bidx];
      hdr_d.sample_rate_hz = srate_lookup(ver, sri);
      hdr_d.pad            = header_word_i[9];
      hdr_d.slot4          = (lay == LAYER_1);
      if (ver == VER_MPEG1) begin
        hdr_d.shift = 2'd2;
      end else if (ver == VER_MPEG2) begin
        hdr_d.shift = 2'd1;
      end else begin
        hdr_d.shift = 2'd0;
      end
      unique case (lay)
        LAYER_1: hdr_d.samples_per_frame = 11'd384;
        LAYER_2: hdr_d.samples_per_frame = 11'd1152;
        default: begin
          if (ver == VER_MPEG1) begin
            hdr_d.samples_per_frame = 11'd1152;
            hdr_d.side_info_bytes   = (mode == MODE_MONO) ? 6'd17 : 6'd32;
          end else begin
            hdr_d.samples_per_frame = 11'd576;
            hdr_d.side_info_bytes   = (mode == MODE_MONO) ? 6'd9 : 6'd17;
          end
        end
      endcase
      // hz = base * 2^shift with base 12000, 8000 or 11025
      unique case (sri)
        2'd1: begin
          hdr_d.div_sel = DIV_ONE;
          hdr_d.mult = (cidx == 2'd0) ? 11'd1 : (cidx == 2'd1) ? 11'd12 : 11'd6;
        end
        2'd2: begin
          hdr_d.div_sel = DIV_TWO;
          hdr_d.mult = (cidx == 2'd0) ? 11'd3 : (cidx == 2'd1) ? 11'd36 : 11'd18;
        end
        default: begin
          hdr_d.div_sel = DIV_147;
          hdr_d.mult = (cidx == 2'd0) ? 11'd160 : (cidx == 2'd1) ? 11'd1920 : 11'd960;
        end
      endcase
    end
  end

  assign ready      = !v_q || dec_ready_i;
  assign in_stall_o = !ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      hdr_q <= hdr_d;
    end
  end

  assign dec_valid_o = v_q;
  assign dec_o       = hdr_q;

endmodule

[rtl/mahd_frame_size.sv]
// Second and third pipeline stages: frame length from bitrate and sample rate.
// Multiply by a per-case factor, then divide by 1, 2 or 147 via reciprocal.
// Depends on mahd_pkg.
module mahd_frame_size import mahd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic hdr_valid_i,
  output logic hdr_ready_o,
  input  hdr_t hdr_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  logic        v2_q, v3_q;
  logic        ready2, ready3;
  hdr_t        h2_q, h3_q;
  logic [19:0] x_d, x2_q, x3_q;
  logic [39:0] p_d, p3_q;

  logic [19:0] quot, quot_sh, slots, fbytes;

  assign x_d = 20'(hdr_i.bitrate_kbps) * 20'(hdr_i.mult);
  assign p_d = 40'(x2_q) * 40'(RECIP_147);

  assign ready3      = !v3_q || res_ready_i;
  assign ready2      = !v2_q || ready3;
  assign hdr_ready_o = ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready2) begin
        v2_q <= hdr_valid_i;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && hdr_valid_i) begin
      h2_q <= hdr_i;
      x2_q <= x_d;
    end
    if (ready3 && v2_q) begin
      h3_q <= h2_q;
      x3_q <= x2_q;
      p3_q <= p_d;
    end
  end

  always_comb begin
    case (h3_q.div_sel)
      DIV_TWO: quot = x3_q >> 1;
      DIV_147: quot = 20'(p3_q[39:RECIP_SHIFT]);
      default: quot = x3_q;
    endcase
    quot_sh = quot >> h3_q.shift;
    slots   = quot_sh + 20'(h3_q.pad);
    fbytes  = h3_q.slot4 ? (slots << 2) : slots;
  end

  always_comb begin
    res_o.status            = h3_q.status;
    res_o.version_code      = h3_q.version_code;
    res_o.layer_code        = h3_q.layer_code;
    res_o.bitrate_kbps      = h3_q.bitrate_kbps;
    res_o.sample_rate_hz    = h3_q.sample_rate_hz;
    res_o.samples_per_frame = h3_q.samples_per_frame;
    res_o.frame_bytes       = fbytes[11:0];
    res_o.crc_bytes         = h3_q.crc_bytes;
    res_o.side_info_bytes   = h3_q.side_info_bytes;
  end

  assign res_valid_o = v3_q;

endmodule

[rtl/mpeg_audio_header_decoder.sv]
// MPEG audio frame header decoder, top level.
// Stages from input request to result: decode, multiply, reciprocal multiply,
// output register. Throughput: one request per cycle while out_stall_i is low;
// a stall holds every occupied stage and bubbles are squeezed out.
// Reset clears all stage valid bits; data registers are not reset.
// Depends on mahd_pkg, mahd_decode and mahd_frame_size.
module mpeg_audio_header_decoder import mahd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  version_code_o,
  output logic [1:0]  layer_code_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic [10:0] samples_per_frame_o,
  output logic [11:0] frame_bytes_o,
  output logic [1:0]  crc_bytes_o,
  output logic [5:0]  side_info_bytes_o
);

  logic dec_valid, dec_ready;
  hdr_t dec_hdr;
  logic res_valid, res_ready;
  res_t res;

  logic out_valid_q;
  res_t out_q;

  mahd_decode u_decode (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .header_word_i,
    .dec_valid_o (dec_valid),
    .dec_ready_i (dec_ready),
    .dec_o       (dec_hdr)
  );

  mahd_frame_size u_frame_size (
    .clk_i,
    .rst_ni,
    .hdr_valid_i (dec_valid),
    .hdr_ready_o (dec_ready),
    .hdr_i       (dec_hdr),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = 3'(out_q.status);
  assign version_code_o      = out_q.version_code;
  assign layer_code_o        = out_q.layer_code;
  assign bitrate_kbps_o      = out_q.bitrate_kbps;
  assign sample_rate_hz_o    = out_q.sample_rate_hz;
  assign samples_per_frame_o = out_q.samples_per_frame;
  assign frame_bytes_o       = out_q.frame_bytes;
  assign crc_bytes_o         = out_q.crc_bytes;
  assign side_info_bytes_o   = out_q.side_info_bytes;

endmodule

[test/tb.sv]
// Testbench for mpeg_audio_header_decoder: drives frame headers and checks every decoded result.
// A scoreboard class predicts each decode from the header bits and compares it field by field.
// Depends on mahd_pkg and the decoder RTL.
module tb import mahd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class hdr_scoreboard;
    res_t pending_decodes[$];
    int   mismatches = 0;
    int unsigned kbps_tab [5][14] = '{
      '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
      '{32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
      '{32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
      '{8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
      '{32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256}
    };

    function res_t decode_header(logic [31:0] h);
      res_t        r;
      logic [1:0]  ver, lay, sri;
      logic [3:0]  bri;
      logic        pad, mono;
      int unsigned row, kbps, hz, frame;
      ver  = h[20:19];
      lay  = h[18:17];
      bri  = h[15:12];
      sri  = h[11:10];
      pad  = h[9];
      mono = (h[7:6] == MODE_MONO);
      r = '0;
      r.version_code = ver;
      r.layer_code   = lay;
      r.crc_bytes    = h[16] ? 2'd0 : 2'd2;
      if (ver == VER_RSVD) r.status = ST_BAD_VER;
      else if (lay == LAYER_RSVD) r.status = ST_BAD_LAYER;
      else if (bri == BRI_FREE || bri == BRI_BAD) r.status = ST_BAD_RATE;
      else if (sri == SRI_RSVD) r.status = ST_BAD_SRATE;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        if (ver == VER_MPEG1) row = (lay == LAYER_1) ? 2 : (lay == LAYER_2) ? 1 : 0;
        else row = (lay == LAYER_1) ? 4 : 3;
        kbps = kbps_tab[row][bri - 4'd1];
        hz = (sri == 2'd0) ? 44100 : (sri == 2'd1) ? 48000 : 32000;
        if (ver == VER_MPEG2) hz = hz / 2;
        else if (ver == VER_MPEG25) hz = hz / 4;
        case (lay)
          LAYER_1: begin
            r.samples_per_frame = 11'd384;
            frame = (12000 * kbps / hz + pad) * 4;
          end
          LAYER_2: begin
            r.samples_per_frame = 11'd1152;
            frame = 144000 * kbps / hz + pad;
          end
          default: begin
            if (ver == VER_MPEG1) begin
              r.samples_per_frame = 11'd1152;
              frame = 144000 * kbps / hz + pad;
              r.side_info_bytes = mono ? 6'd17 : 6'd32;
            end else begin
              r.samples_per_frame = 11'd576;
              frame = 72000 * kbps / hz + pad;
              r.side_info_bytes = mono ? 6'd9 : 6'd17;
            end
          end
        endcase
        r.bitrate_kbps   = kbps[8:0];
        r.sample_rate_hz = hz[15:0];
        r.frame_bytes    = frame[11:0];
      end
      return r;
    endfunction

    function void note_header(logic [31:0] h);
      pending_decodes.push_back(decode_header(h));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_decode(res_t got);
      res_t want;
      if (pending_decodes.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_decodes.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("version_code", got.version_code, want.version_code);
        compare_field("layer_code", got.layer_code, want.layer_code);
        compare_field("bitrate_kbps", got.bitrate_kbps, want.bitrate_kbps);
        compare_field("sample_rate_hz", got.sample_rate_hz, want.sample_rate_hz);
        compare_field("samples_per_frame", got.samples_per_frame, want.samples_per_frame);
        compare_field("frame_bytes", got.frame_bytes, want.frame_bytes);
        compare_field("crc_bytes", got.crc_bytes, want.crc_bytes);
        compare_field("side_info_bytes", got.side_info_bytes, want.side_info_bytes);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] header_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [1:0]  version_code;
  logic [1:0]  layer_code;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [10:0] samples_per_frame;
  logic [11:0] frame_bytes;
  logic [1:0]  crc_bytes;
  logic [5:0]  side_info_bytes;

  hdr_scoreboard sb = new();
  bit no_idle = 1'b0;
  int long_hold = 0;

  mpeg_audio_header_decoder uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .header_word_i       (header_word),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status),
    .version_code_o      (version_code),
    .layer_code_o        (layer_code),
    .bitrate_kbps_o      (bitrate_kbps),
    .sample_rate_hz_o    (sample_rate_hz),
    .samples_per_frame_o (samples_per_frame),
    .frame_bytes_o       (frame_bytes),
    .crc_bytes_o         (crc_bytes),
    .side_info_bytes_o   (side_info_bytes)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // private bit and the low six bits are filled at random
  function automatic logic [31:0] pack_header(logic [10:0] sync, logic [1:0] ver,
                                              logic [1:0] lay, logic prot, logic [3:0] bri,
                                              logic [1:0] sri, logic pad, logic [1:0] mode);
    logic [6:0] filler;
    filler = 7'($urandom);
    return {sync, ver, lay, prot, bri, sri, pad, filler[6], mode, filler[5:0]};
  endfunction

  function automatic logic [31:0] legal_header();
    logic [1:0] ver;
    case ($urandom_range(0, 2))
      0:       ver = VER_MPEG1;
      1:       ver = VER_MPEG2;
      default: ver = VER_MPEG25;
    endcase
    return pack_header(11'h7FF, ver, 2'($urandom_range(1, 3)), 1'($urandom),
                       4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
                       1'($urandom), 2'($urandom));
  endfunction

  task send_header(logic [31:0] h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    header_word <= h;
    do @(posedge clk); while (in_stall);
    sb.note_header(h);
  endtask

  initial begin
    int   hold;
    res_t got;
    wait (rst_n);
    forever begin
      hold = (long_hold > 0) ? long_hold : (no_idle ? 0 : $urandom_range(0, 10));
      long_hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.status            = status_e'(status);
      got.version_code      = version_code;
      got.layer_code        = layer_code;
      got.bitrate_kbps      = bitrate_kbps;
      got.sample_rate_hz    = sample_rate_hz;
      got.samples_per_frame = samples_per_frame;
      got.frame_bytes       = frame_bytes;
      got.crc_bytes         = crc_bytes;
      got.side_info_bytes   = side_info_bytes;
      sb.check_decode(got);
    end
  end

  initial begin
    logic [1:0] vers [3] = '{VER_MPEG1, VER_MPEG2, VER_MPEG25};
    logic [1:0] lays [3] = '{LAYER_1, LAYER_2, LAYER_3};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_header(32'h0000_0000);
    send_header(32'hFFFF_FFFF);
    // every version and layer at top bitrate, lowest rate, padded
    foreach (vers[v])
      foreach (lays[l])
        send_header(pack_header(11'h7FF, vers[v], lays[l], 1'(l), 4'd14, 2'd2, 1'b1,
                                (v == l) ? MODE_MONO : 2'd0));
    send_header(pack_header(11'h7FF, VER_MPEG1, LAYER_3, 1'b1, 4'd1, 2'd1, 1'b0, 2'd1));
    send_header(pack_header(11'h7FF, VER_MPEG2, LAYER_3, 1'b0, 4'd1, 2'd0, 1'b0, MODE_MONO));
    send_header(pack_header(11'h7FF, VER_MPEG25, LAYER_2, 1'b1, 4'd1, 2'd0, 1'b1, 2'd2));
    send_header(pack_header(11'h7FF, VER_MPEG1, LAYER_2, 1'b0, BRI_FREE, 2'd0, 1'b0, 2'd0));
    send_header(pack_header(11'h7FF, VER_MPEG2, LAYER_1, 1'b1, BRI_BAD, 2'd1, 1'b0, 2'd0));
    send_header(pack_header(11'h7FF, VER_MPEG1, LAYER_1, 1'b0, 4'd5, SRI_RSVD, 1'b1, 2'd0));
    send_header(pack_header(11'h7FF, VER_RSVD, LAYER_RSVD, 1'b0, BRI_BAD, SRI_RSVD, 1'b0,
                            2'd0));
    send_header(pack_header(11'h7FF, VER_MPEG1, LAYER_RSVD, 1'b1, BRI_FREE, SRI_RSVD, 1'b0,
                            2'd0));
    send_header(pack_header(11'h7FF, VER_MPEG25, LAYER_3, 1'b1, BRI_FREE, SRI_RSVD, 1'b1,
                            MODE_MONO));
    send_header(pack_header(11'h000, VER_MPEG1, LAYER_3, 1'b1, 4'd9, 2'd0, 1'b1, 2'd0));
    send_header(pack_header(11'h2A5, VER_MPEG2, LAYER_2, 1'b0, 4'd7, 2'd2, 1'b0, MODE_MONO));

    for (int i = 0; i < 950; i++) begin
      // back-to-back stretches; the first one runs into a long output hold
      no_idle = (i >= 300 && i < 450) || (i >= 700 && i < 780);
      if (i == 300) long_hold = 80;
      if ($urandom_range(0, 3) == 0) send_header($urandom);
      else send_header(legal_header());
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
